/* rtl/core/assert_macros.svh */
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion forms for the checker files.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define ASSERT_SAME(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled during reset.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

// Next-cycle implication, live through reset.
`define ASSERT_NEXT_ALWAYS(lbl, clk, ante, cons) \
    lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error("assertion failed: next-cycle implication");

`endif

/* rtl/core/rrf_pkg.sv */
// ----------------------------------------------------------------------------
// Rectangle raster fill package
// Widths, register indexes, request codes and shared types.
// ----------------------------------------------------------------------------
`default_nettype none

package rrf_pkg;

    localparam int MAX_SIDE   = 256;
    localparam int FRAC_BITS  = 8;
    localparam int SIDE_W     = $clog2(MAX_SIDE);
    localparam int CNT_W      = SIDE_W + 1;
    localparam int ADDR_W     = 2 * SIDE_W;
    localparam int MEM_DEPTH  = 1 << ADDR_W;
    localparam int COORD_W    = 19;
    localparam int EXT_W      = COORD_W + 2;
    localparam int CODE_W     = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 9;

    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_WIDTH    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CANVAS_HEIGHT   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_BACKGROUND_CODE = 2'd2;

    localparam logic [CNT_W-1:0]  CANVAS_WIDTH_RST  = CNT_W'(256);
    localparam logic [CNT_W-1:0]  CANVAS_HEIGHT_RST = CNT_W'(256);
    localparam logic [CODE_W-1:0] BACKGROUND_RST    = CODE_W'(32);

    localparam logic signed [EXT_W-1:0] ONE_FIX = EXT_W'(1) << FRAC_BITS;

    typedef enum logic [1:0] {
        REQ_CLEAR = 2'd0,
        REQ_DRAW  = 2'd1,
        REQ_READ  = 2'd2
    } t_req_kind;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SETUP,
        ST_ROW,
        ST_SCAN,
        ST_READ,
        ST_RDATA,
        ST_RESP
    } t_state;

    typedef enum logic [2:0] {
        SU_XHI,
        SU_YHI,
        SU_XLO1,
        SU_YLO1,
        SU_XHI1,
        SU_YHI1
    } t_setup_step;

    typedef struct packed {
        logic [1:0]                req_type;
        logic signed [COORD_W-1:0] rect_left;
        logic signed [COORD_W-1:0] rect_top;
        logic signed [COORD_W-1:0] rect_width;
        logic signed [COORD_W-1:0] rect_height;
        logic                      filled;
        logic [CODE_W-1:0]         paint_code;
        logic [SIDE_W-1:0]         read_row;
        logic [SIDE_W-1:0]         read_col;
    } t_req_pl;

    typedef struct packed {
        logic signed [EXT_W-1:0] pos;
        logic signed [EXT_W-1:0] lo;
        logic signed [EXT_W-1:0] lo1;
        logic signed [EXT_W-1:0] hi;
        logic signed [EXT_W-1:0] hi1;
    } t_axis_q;

    typedef struct packed {
        logic in_span;
        logic on_border;
    } t_axis_r;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        logic [CODE_W-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic              valid;
        logic              status;
        logic [CODE_W-1:0] pixel;
    } t_result;

endpackage

`default_nettype wire

/* rtl/core/rrf_ifs.sv */
// ----------------------------------------------------------------------------
// Rectangle raster fill channels
// Request and response valid/ready channels.
// ----------------------------------------------------------------------------
`default_nettype none

interface rrf_req_if import rrf_pkg::*; ();
    logic                      valid;
    logic                      ready;
    logic [1:0]                req_type;
    logic signed [COORD_W-1:0] rect_left;
    logic signed [COORD_W-1:0] rect_top;
    logic signed [COORD_W-1:0] rect_width;
    logic signed [COORD_W-1:0] rect_height;
    logic                      filled;
    logic [CODE_W-1:0]         paint_code;
    logic [SIDE_W-1:0]         read_row;
    logic [SIDE_W-1:0]         read_col;

    modport source (
        output valid, req_type, rect_left, rect_top, rect_width, rect_height,
               filled, paint_code, read_row, read_col,
        input  ready
    );
    modport sink (
        input  valid, req_type, rect_left, rect_top, rect_width, rect_height,
               filled, paint_code, read_row, read_col,
        output ready
    );
endinterface

interface rrf_rsp_if import rrf_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              status;
    logic [CODE_W-1:0] pixel_code;

    modport source (output valid, status, pixel_code, input ready);
    modport sink (input valid, status, pixel_code, output ready);
endinterface

`default_nettype wire

/* rtl/core/rrf_ram.sv */
// ----------------------------------------------------------------------------
// Generic single-port RAM
// One write or read address per cycle, registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rrf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_addr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

`default_nettype wire

/* rtl/core/rrf_axis_unit.sv */
// ----------------------------------------------------------------------------
// Rectangle raster fill axis compare unit
// Shared window compare for one axis: inside span and near-edge flags.
// ----------------------------------------------------------------------------
`default_nettype none

module rrf_axis_unit import rrf_pkg::*; (
    input  wire t_axis_q i_q,
    output t_axis_r      o_r
);

    logic signed [EXT_W-1:0] pos;
    logic signed [EXT_W-1:0] lo;
    logic signed [EXT_W-1:0] lo1;
    logic signed [EXT_W-1:0] hi;
    logic signed [EXT_W-1:0] hi1;

    assign pos = i_q.pos;
    assign lo  = i_q.lo;
    assign lo1 = i_q.lo1;
    assign hi  = i_q.hi;
    assign hi1 = i_q.hi1;

    always_comb begin
        o_r.in_span   = (pos >= lo) && (pos <= hi);
        o_r.on_border = (pos < lo1) || (pos > hi1);
    end

endmodule

`default_nettype wire

/* rtl/core/rrf_seq.sv */
// ----------------------------------------------------------------------------
// Rectangle raster fill sequencer
// Setup adder, row/column scan counters and canvas access control.
// ----------------------------------------------------------------------------
`default_nettype none

module rrf_seq import rrf_pkg::*; (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_start,
    input  wire t_req_pl           i_req,
    input  wire logic [CNT_W-1:0]  i_cols,
    input  wire logic [CNT_W-1:0]  i_rows,
    input  wire logic [CODE_W-1:0] i_bg,
    input  wire logic              i_res_free,
    input  wire t_axis_r           i_ax,
    input  wire logic [CODE_W-1:0] i_mem_rdata,
    output logic                   o_idle,
    output t_axis_q                o_ax,
    output t_mem_req               o_mem,
    output t_result                o_res
);

    t_state                  r_state;
    t_state                  n_state;
    t_setup_step             r_step;
    logic                    r_is_clear;
    logic                    r_fill;
    logic [CODE_W-1:0]       r_code;
    logic [SIDE_W-1:0]       r_rrow;
    logic [SIDE_W-1:0]       r_rcol;
    logic signed [EXT_W-1:0] r_x;
    logic signed [EXT_W-1:0] r_y;
    logic signed [EXT_W-1:0] r_w;
    logic signed [EXT_W-1:0] r_h;
    logic signed [EXT_W-1:0] r_xhi;
    logic signed [EXT_W-1:0] r_yhi;
    logic signed [EXT_W-1:0] r_xlo1;
    logic signed [EXT_W-1:0] r_ylo1;
    logic signed [EXT_W-1:0] r_xhi1;
    logic signed [EXT_W-1:0] r_yhi1;
    logic [SIDE_W-1:0]       r_row;
    logic [SIDE_W-1:0]       r_col;
    logic                    r_row_in;
    logic                    r_row_bd;
    logic                    r_status;
    logic [CODE_W-1:0]       r_pixel;

    logic                    empty;
    logic                    bad_rect;
    logic                    col_last;
    logic                    row_last;
    logic signed [EXT_W-1:0] add_a;
    logic signed [EXT_W-1:0] add_b;
    logic signed [EXT_W-1:0] add_sum;

    assign empty    = (i_cols == '0) || (i_rows == '0);
    assign bad_rect = i_req.rect_width[COORD_W-1] || (i_req.rect_width == '0)
                   || i_req.rect_height[COORD_W-1] || (i_req.rect_height == '0);
    assign col_last = ({1'b0, r_col} == (i_cols - CNT_W'(1)));
    assign row_last = ({1'b0, r_row} == (i_rows - CNT_W'(1)));

    always_comb begin
        add_a = '0;
        add_b = '0;
        unique case (r_step)
            SU_XHI:  begin add_a = r_x;   add_b = r_w;      end
            SU_YHI:  begin add_a = r_y;   add_b = r_h;      end
            SU_XLO1: begin add_a = r_x;   add_b = ONE_FIX;  end
            SU_YLO1: begin add_a = r_y;   add_b = ONE_FIX;  end
            SU_XHI1: begin add_a = r_xhi; add_b = -ONE_FIX; end
            SU_YHI1: begin add_a = r_yhi; add_b = -ONE_FIX; end
            default: begin add_a = '0;    add_b = '0;       end
        endcase
        add_sum = add_a + add_b;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    unique case (i_req.req_type)
                        REQ_CLEAR: n_state = empty ? ST_RESP : ST_ROW;
                        REQ_DRAW:  n_state = bad_rect ? ST_RESP : ST_SETUP;
                        REQ_READ:  n_state = ST_READ;
                        default:   n_state = ST_RESP;
                    endcase
                end
            end
            ST_SETUP: begin
                if (r_step == SU_YHI1) begin
                    n_state = empty ? ST_RESP : ST_ROW;
                end
            end
            ST_ROW:  n_state = ST_SCAN;
            ST_SCAN: begin
                if (col_last) begin
                    n_state = row_last ? ST_RESP : ST_ROW;
                end
            end
            ST_READ:  n_state = ST_RDATA;
            ST_RDATA: n_state = ST_RESP;
            ST_RESP: begin
                if (i_res_free) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_idle        = (r_state == ST_IDLE);
        o_ax.pos      = EXT_W'(r_col) << FRAC_BITS;
        o_ax.lo       = r_x;
        o_ax.lo1      = r_xlo1;
        o_ax.hi       = r_xhi;
        o_ax.hi1      = r_xhi1;
        o_mem.we      = 1'b0;
        o_mem.addr    = {r_row, r_col};
        o_mem.wdata   = r_is_clear ? i_bg : r_code;
        o_res.valid   = 1'b0;
        o_res.status  = r_status;
        o_res.pixel   = r_pixel;
        unique case (r_state)
            ST_ROW: begin
                o_ax.pos = EXT_W'(r_row) << FRAC_BITS;
                o_ax.lo  = r_y;
                o_ax.lo1 = r_ylo1;
                o_ax.hi  = r_yhi;
                o_ax.hi1 = r_yhi1;
            end
            ST_SCAN: begin
                o_mem.we = r_is_clear || (r_row_in && i_ax.in_span
                           && (r_fill || r_row_bd || i_ax.on_border));
            end
            ST_READ:  o_mem.addr  = {r_rrow, r_rcol};
            ST_RESP:  o_res.valid = 1'b1;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (r_state)
            ST_IDLE: begin
                if (i_start) begin
                    r_is_clear <= (i_req.req_type == REQ_CLEAR);
                    r_fill     <= i_req.filled;
                    r_code     <= i_req.paint_code;
                    r_rrow     <= i_req.read_row;
                    r_rcol     <= i_req.read_col;
                    r_x <= {{(EXT_W-COORD_W){i_req.rect_left[COORD_W-1]}}, i_req.rect_left};
                    r_y <= {{(EXT_W-COORD_W){i_req.rect_top[COORD_W-1]}}, i_req.rect_top};
                    r_w <= {{(EXT_W-COORD_W){i_req.rect_width[COORD_W-1]}},
                            i_req.rect_width};
                    r_h <= {{(EXT_W-COORD_W){i_req.rect_height[COORD_W-1]}},
                            i_req.rect_height};
                    r_status   <= (i_req.req_type == REQ_DRAW) && bad_rect;
                    r_pixel    <= '0;
                    r_step     <= SU_XHI;
                    r_row      <= '0;
                    r_col      <= '0;
                end
            end
            ST_SETUP: begin
                unique case (r_step)
                    SU_XHI:  r_xhi  <= add_sum;
                    SU_YHI:  r_yhi  <= add_sum;
                    SU_XLO1: r_xlo1 <= add_sum;
                    SU_YLO1: r_ylo1 <= add_sum;
                    SU_XHI1: r_xhi1 <= add_sum;
                    SU_YHI1: r_yhi1 <= add_sum;
                    default: ;
                endcase
                r_step <= t_setup_step'(r_step + 3'd1);
            end
            ST_ROW: begin
                r_row_in <= i_ax.in_span;
                r_row_bd <= i_ax.on_border;
                r_col    <= '0;
            end
            ST_SCAN: begin
                if (col_last) begin
                    r_row <= r_row + SIDE_W'(1);
                end else begin
                    r_col <= r_col + SIDE_W'(1);
                end
            end
            ST_RDATA: r_pixel <= i_mem_rdata;
            default: ;
        endcase
    end

endmodule

`default_nettype wire

/* rtl/core/rectangle_raster_fill_unit.sv */
// ----------------------------------------------------------------------------
// Rectangle raster fill unit
// Character canvas engine: clear, draw rectangle (filled or outline), read.
//
//   port      dir   kind       content
//   i_req     in    valid/rdy  req_type, rect_*, filled, paint_code, read_*
//   o_rsp     out   valid/rdy  status, pixel_code
//   i_cfg_*   in    write      canvas_width, canvas_height, background_code
//
// Clear and draw scan through the one canvas RAM port, one column at a time,
// with a row-compare step before each row. One transaction at a time;
// i_req.ready is high only while idle. A finished response sits in an output
// register, so the next request is taken while it waits. Synchronous
// active-low reset; the canvas holds no reset value and must be cleared
// before it is read.
// ----------------------------------------------------------------------------
`default_nettype none

module rectangle_raster_fill_unit import rrf_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  wire logic [CFG_DATA_W-1:0] i_cfg_data,
    rrf_req_if.sink                    i_req,
    rrf_rsp_if.source                  o_rsp
);

    logic [CNT_W-1:0]  r_cfg_w;
    logic [CNT_W-1:0]  r_cfg_h;
    logic [CODE_W-1:0] r_bg;
    logic              r_out_valid;
    logic              r_out_status;
    logic [CODE_W-1:0] r_out_pixel;

    logic [CNT_W-1:0]  cols;
    logic [CNT_W-1:0]  rows;
    logic              idle;
    logic              start;
    logic              res_free;
    t_req_pl           req_pl;
    t_axis_q           ax_q;
    t_axis_r           ax_r;
    t_mem_req          mem;
    t_result           res;
    logic [CODE_W-1:0] mem_rdata;

    assign cols = (r_cfg_w > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : r_cfg_w;
    assign rows = (r_cfg_h > CNT_W'(MAX_SIDE)) ? CNT_W'(MAX_SIDE) : r_cfg_h;

    assign i_req.ready = idle;
    assign start       = i_req.valid && idle;
    assign res_free    = !r_out_valid || o_rsp.ready;

    always_comb begin
        req_pl.req_type    = i_req.req_type;
        req_pl.rect_left   = i_req.rect_left;
        req_pl.rect_top    = i_req.rect_top;
        req_pl.rect_width  = i_req.rect_width;
        req_pl.rect_height = i_req.rect_height;
        req_pl.filled      = i_req.filled;
        req_pl.paint_code  = i_req.paint_code;
        req_pl.read_row    = i_req.read_row;
        req_pl.read_col    = i_req.read_col;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_w <= CANVAS_WIDTH_RST;
            r_cfg_h <= CANVAS_HEIGHT_RST;
            r_bg    <= BACKGROUND_RST;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_CANVAS_WIDTH:    r_cfg_w <= i_cfg_data;
                REG_CANVAS_HEIGHT:   r_cfg_h <= i_cfg_data;
                REG_BACKGROUND_CODE: r_bg    <= i_cfg_data[CODE_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (res.valid && res_free) begin
            r_out_valid <= 1'b1;
        end else if (o_rsp.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res.valid && res_free) begin
            r_out_status <= res.status;
            r_out_pixel  <= res.pixel;
        end
    end

    assign o_rsp.valid      = r_out_valid;
    assign o_rsp.status     = r_out_status;
    assign o_rsp.pixel_code = r_out_pixel;

    rrf_seq u_seq (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (start),
        .i_req       (req_pl),
        .i_cols      (cols),
        .i_rows      (rows),
        .i_bg        (r_bg),
        .i_res_free  (res_free),
        .i_ax        (ax_r),
        .i_mem_rdata (mem_rdata),
        .o_idle      (idle),
        .o_ax        (ax_q),
        .o_mem       (mem),
        .o_res       (res)
    );

    rrf_axis_unit u_axis (
        .i_q (ax_q),
        .o_r (ax_r)
    );

    rrf_ram #(
        .WIDTH (CODE_W),
        .DEPTH (MEM_DEPTH)
    ) u_canvas (
        .i_clk   (i_clk),
        .i_we    (mem.we),
        .i_addr  (mem.addr),
        .i_wdata (mem.wdata),
        .o_rdata (mem_rdata)
    );

endmodule

`default_nettype wire

/* rtl/core/rrf_checker.sv */
// ----------------------------------------------------------------------------
// Rectangle raster fill checker
// Port-level assertions on the response channel and request acceptance.
// ----------------------------------------------------------------------------
`default_nettype none

`include "assert_macros.svh"

module rrf_checker import rrf_pkg::*; (
    input wire logic              i_clk,
    input wire logic              i_rst_n,
    input wire logic              i_req_valid,
    input wire logic              i_req_ready,
    input wire logic              i_rsp_valid,
    input wire logic              i_rsp_ready,
    input wire logic              i_rsp_status,
    input wire logic [CODE_W-1:0] i_rsp_pixel
);

    `ASSERT_NEXT_ALWAYS(a_rst_no_rsp, i_clk, !i_rst_n, !i_rsp_valid)

    `ASSERT_NEXT(a_busy_after_req, i_clk, i_rst_n, i_req_valid && i_req_ready, !i_req_ready)

    `ASSERT_SAME(a_err_no_pixel, i_clk, i_rst_n, i_rsp_valid && i_rsp_status, i_rsp_pixel == '0)

    `ASSERT_NEXT(a_rsp_hold, i_clk, i_rst_n, i_rsp_valid && !i_rsp_ready, i_rsp_valid && $stable(i_rsp_pixel) && $stable(i_rsp_status))

endmodule

bind rectangle_raster_fill_unit rrf_checker u_rrf_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_req_valid  (i_req.valid),
    .i_req_ready  (i_req.ready),
    .i_rsp_valid  (o_rsp.valid),
    .i_rsp_ready  (o_rsp.ready),
    .i_rsp_status (o_rsp.status),
    .i_rsp_pixel  (o_rsp.pixel_code)
);

`default_nettype wire

/* tb/rrf_canvas_monitor.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle raster fill canvas monitor
// Watches the configuration port and both channels, keeps a mirror of the
// canvas and the canvas registers, predicts the reply to every accepted
// request and compares each reply field by field, in order.
// ----------------------------------------------------------------------------

module rrf_canvas_monitor import rrf_pkg::*; (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    rrf_req_if                    i_req,
    rrf_rsp_if                    i_rsp,
    output int                    o_pending_replies,
    output int                    o_fail_count
);

    typedef struct packed {
        logic              status;
        logic [CODE_W-1:0] pixel_code;
    } t_reply;

    logic [CODE_W-1:0]     canvas_copy [MEM_DEPTH];
    logic [CFG_DATA_W-1:0] cols_reg;
    logic [CFG_DATA_W-1:0] rows_reg;
    logic [CODE_W-1:0]     bg_reg;
    t_reply                awaited_replies [$];
    int                    mismatches;

    initial begin
        mismatches        = 0;
        o_pending_replies = 0;
        o_fail_count      = 0;
    end

    function automatic int clamp_side(input logic [CFG_DATA_W-1:0] v);
        return (v > MAX_SIDE) ? MAX_SIDE : int'(v);
    endfunction

    // Apply one request to the canvas mirror and return its reply.
    function automatic t_reply rasterise(input t_req_pl rq);
        t_reply                  ans;
        int                      cols;
        int                      rows;
        int                      r;
        int                      c;
        logic signed [EXT_W-1:0] x;
        logic signed [EXT_W-1:0] y;
        logic signed [EXT_W-1:0] w;
        logic signed [EXT_W-1:0] h;
        logic signed [EXT_W-1:0] px;
        logic signed [EXT_W-1:0] py;
        logic                    in_box;
        logic                    on_rim;
        ans  = '0;
        cols = clamp_side(cols_reg);
        rows = clamp_side(rows_reg);
        case (rq.req_type)
            REQ_CLEAR: begin
                for (r = 0; r < rows; r++)
                    for (c = 0; c < cols; c++)
                        canvas_copy[r * MAX_SIDE + c] = bg_reg;
            end
            REQ_DRAW: begin
                x = $signed(rq.rect_left);
                y = $signed(rq.rect_top);
                w = $signed(rq.rect_width);
                h = $signed(rq.rect_height);
                if (w <= 0 || h <= 0) begin
                    ans.status = 1'b1;
                end else begin
                    for (r = 0; r < rows; r++) begin
                        py = r << FRAC_BITS;
                        if (py >= y && py <= y + h) begin
                            for (c = 0; c < cols; c++) begin
                                px     = c << FRAC_BITS;
                                in_box = (px >= x) && (px <= x + w);
                                on_rim = (py - y < ONE_FIX) || (y + h - py < ONE_FIX) ||
                                         (px - x < ONE_FIX) || (x + w - px < ONE_FIX);
                                if (in_box && (rq.filled || on_rim))
                                    canvas_copy[r * MAX_SIDE + c] = rq.paint_code;
                            end
                        end
                    end
                end
            end
            REQ_READ: begin
                ans.pixel_code = canvas_copy[int'(rq.read_row) * MAX_SIDE + int'(rq.read_col)];
            end
            default: ;
        endcase
        return ans;
    endfunction

    always @(posedge i_clk) begin
        t_reply  got;
        t_reply  want;
        t_req_pl rq;
        if (!i_rst_n) begin
            cols_reg = CANVAS_WIDTH_RST;
            rows_reg = CANVAS_HEIGHT_RST;
            bg_reg   = BACKGROUND_RST;
            awaited_replies.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    REG_CANVAS_WIDTH:    cols_reg = i_cfg_data;
                    REG_CANVAS_HEIGHT:   rows_reg = i_cfg_data;
                    REG_BACKGROUND_CODE: bg_reg   = i_cfg_data[CODE_W-1:0];
                    default: ;
                endcase
            end
            if (i_rsp.valid && i_rsp.ready) begin
                got.status     = i_rsp.status;
                got.pixel_code = i_rsp.pixel_code;
                if (awaited_replies.size() == 0) begin
                    $error("reply with no request outstanding: status %0d, pixel_code %0d",
                           got.status, got.pixel_code);
                    mismatches++;
                end else begin
                    want = awaited_replies.pop_front();
                    if (got.status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, got.status);
                        mismatches++;
                    end
                    if (got.pixel_code !== want.pixel_code) begin
                        $error("pixel_code: expected %0d, actual %0d",
                               want.pixel_code, got.pixel_code);
                        mismatches++;
                    end
                end
            end
            if (i_req.valid && i_req.ready) begin
                rq.req_type    = i_req.req_type;
                rq.rect_left   = i_req.rect_left;
                rq.rect_top    = i_req.rect_top;
                rq.rect_width  = i_req.rect_width;
                rq.rect_height = i_req.rect_height;
                rq.filled      = i_req.filled;
                rq.paint_code  = i_req.paint_code;
                rq.read_row    = i_req.read_row;
                rq.read_col    = i_req.read_col;
                awaited_replies.push_back(rasterise(rq));
            end
        end
        o_pending_replies <= awaited_replies.size();
        o_fail_count      <= mismatches;
    end

endmodule

/* tb/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Rectangle raster fill unit testbench
// Drives clear, draw and read requests into the unit under several canvas
// settings: a directed pass over field extremes and corner cases, then
// random rounds with varying idle rates and one long reply stall. A canvas
// monitor predicts and checks every reply; this module gives the verdict.
// ----------------------------------------------------------------------------

module testbench;
    import rrf_pkg::*;

    localparam int QUIET_LIMIT   = 300000;
    localparam int HOLD_CYCLES   = 600;
    localparam int RANDOM_ROUNDS = 9;
    localparam int ROUND_ITEMS   = 8;
    localparam int ONE_UNIT      = 1 << FRAC_BITS;
    localparam int COORD_MIN     = -(1 << (COORD_W - 1));
    localparam int COORD_MAX     = (1 << (COORD_W - 1)) - 1;

    localparam logic [1:0]        REQ_UNKNOWN  = 2'd3;
    localparam logic [CODE_W-1:0] CODE_LOWER_R = "r";
    localparam logic [CODE_W-1:0] CODE_UPPER_R = "R";

    logic                  i_clk      = 1'b0;
    logic                  i_rst_n    = 1'b0;
    logic                  i_cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_idx  = REG_CANVAS_WIDTH;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;

    int send_gap_pct = 8;
    int recv_gap_pct = 78;
    int hold_asked   = 0;
    int quiet_cycles = 0;
    int canvas_cols  = MAX_SIDE;
    int canvas_rows  = MAX_SIDE;
    int pending_replies;
    int fail_count;

    rrf_req_if req_ch ();
    rrf_rsp_if rsp_ch ();

    rectangle_raster_fill_unit dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_req      (req_ch),
        .o_rsp      (rsp_ch)
    );

    rrf_canvas_monitor canvas_monitor (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_idx         (i_cfg_idx),
        .i_cfg_data        (i_cfg_data),
        .i_req             (req_ch),
        .i_rsp             (rsp_ch),
        .o_pending_replies (pending_replies),
        .o_fail_count      (fail_count)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("rectangle_raster_fill_unit verification failed");
            $finish;
        end
    end

    // Reply side: random back-pressure, plus a long hold on request.
    initial begin
        int hold_seen;
        int hold_left;
        hold_seen    = 0;
        hold_left    = 0;
        rsp_ch.ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (hold_asked != hold_seen) begin
                hold_seen = hold_asked;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end else begin
                rsp_ch.ready <= ($urandom_range(99) >= recv_gap_pct);
            end
        end
    end

    function automatic logic [COORD_W-1:0] fix_between(input int lo, input int hi);
        return COORD_W'(lo + int'($urandom_range(hi - lo)));
    endfunction

    function automatic t_req_pl scrambled_request();
        logic [127:0] noise;
        noise = {$urandom, $urandom, $urandom, $urandom};
        return noise[$bits(t_req_pl)-1:0];
    endfunction

    function automatic t_req_pl plain_request(input logic [1:0] kind);
        t_req_pl rq;
        rq          = scrambled_request();
        rq.req_type = kind;
        return rq;
    endfunction

    function automatic t_req_pl draw_request(input int x, input int y, input int w,
                                             input int h, input logic fill,
                                             input logic [CODE_W-1:0] code);
        t_req_pl rq;
        rq             = plain_request(REQ_DRAW);
        rq.rect_left   = COORD_W'(x);
        rq.rect_top    = COORD_W'(y);
        rq.rect_width  = COORD_W'(w);
        rq.rect_height = COORD_W'(h);
        rq.filled      = fill;
        rq.paint_code  = code;
        return rq;
    endfunction

    function automatic t_req_pl read_request(input int row, input int col);
        t_req_pl rq;
        rq          = plain_request(REQ_READ);
        rq.read_row = SIDE_W'(row);
        rq.read_col = SIDE_W'(col);
        return rq;
    endfunction

    function automatic t_req_pl random_request();
        t_req_pl rq;
        int      pick;
        int      lim_r;
        int      lim_c;
        rq    = scrambled_request();
        pick  = $urandom_range(99);
        lim_r = (canvas_rows + 2 > 255) ? 255 : canvas_rows + 2;
        lim_c = (canvas_cols + 2 > 255) ? 255 : canvas_cols + 2;
        if (pick < 55 || (pick >= 84 && pick < 92)) begin
            rq.req_type = REQ_DRAW;
            if ($urandom_range(2) == 0) begin
                rq.rect_left   = COORD_W'((int'($urandom_range(canvas_cols + 4)) - 2) * ONE_UNIT);
                rq.rect_top    = COORD_W'((int'($urandom_range(canvas_rows + 4)) - 2) * ONE_UNIT);
                rq.rect_width  = COORD_W'(int'($urandom_range(canvas_cols + 4, 1)) * ONE_UNIT);
                rq.rect_height = COORD_W'(int'($urandom_range(canvas_rows + 4, 1)) * ONE_UNIT);
            end else begin
                rq.rect_left   = fix_between(-4 * ONE_UNIT, (canvas_cols + 4) * ONE_UNIT);
                rq.rect_top    = fix_between(-4 * ONE_UNIT, (canvas_rows + 4) * ONE_UNIT);
                rq.rect_width  = fix_between(1, (canvas_cols + 6) * ONE_UNIT);
                rq.rect_height = fix_between(1, (canvas_rows + 6) * ONE_UNIT);
            end
            if (pick >= 84) begin
                if ($urandom_range(1) == 1)
                    rq.rect_width = fix_between(COORD_MIN, 0);
                else
                    rq.rect_height = fix_between(COORD_MIN, 0);
            end
        end else if (pick < 78) begin
            rq.req_type = REQ_READ;
            if (pick < 74) begin
                rq.read_row = SIDE_W'($urandom_range(lim_r));
                rq.read_col = SIDE_W'($urandom_range(lim_c));
            end
        end else if (pick < 84) begin
            rq.req_type = REQ_CLEAR;
        end
        return rq;
    endfunction

    // Offer one request and hold it until the unit accepts it.
    task automatic drive_request(input t_req_pl rq);
        while ($urandom_range(99) < send_gap_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid       <= 1'b1;
        req_ch.req_type    <= rq.req_type;
        req_ch.rect_left   <= rq.rect_left;
        req_ch.rect_top    <= rq.rect_top;
        req_ch.rect_width  <= rq.rect_width;
        req_ch.rect_height <= rq.rect_height;
        req_ch.filled      <= rq.filled;
        req_ch.paint_code  <= rq.paint_code;
        req_ch.read_row    <= rq.read_row;
        req_ch.read_col    <= rq.read_col;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
    endtask

    task automatic drain_replies();
        req_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_replies != 0) @(posedge i_clk);
    endtask

    task automatic program_canvas(input int cols, input int rows, input int bg);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= REG_CANVAS_WIDTH;
        i_cfg_data <= CFG_DATA_W'(cols);
        @(posedge i_clk);
        i_cfg_idx  <= REG_CANVAS_HEIGHT;
        i_cfg_data <= CFG_DATA_W'(rows);
        @(posedge i_clk);
        i_cfg_idx  <= REG_BACKGROUND_CODE;
        i_cfg_data <= CFG_DATA_W'(bg);
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        canvas_cols = (cols > MAX_SIDE) ? MAX_SIDE : cols;
        canvas_rows = (rows > MAX_SIDE) ? MAX_SIDE : rows;
    endtask

    initial begin
        int lap;
        int n;
        int pick;
        int cols;
        int rows;
        req_ch.valid       = 1'b0;
        req_ch.req_type    = REQ_CLEAR;
        req_ch.rect_left   = '0;
        req_ch.rect_top    = '0;
        req_ch.rect_width  = '0;
        req_ch.rect_height = '0;
        req_ch.filled      = 1'b0;
        req_ch.paint_code  = '0;
        req_ch.read_row    = '0;
        req_ch.read_col    = '0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Full canvas at reset settings: clear everything before any read.
        drive_request(plain_request(REQ_CLEAR));
        drive_request(read_request(0, 0));
        drive_request(read_request(255, 255));
        drive_request(draw_request(640, -768, 64064, 66560, 1'b0, CODE_UPPER_R));
        drain_replies();

        program_canvas(12, 10, 8'h2E);
        drive_request(plain_request(REQ_CLEAR));
        drive_request(draw_request(COORD_MIN, COORD_MIN, COORD_MAX, COORD_MAX, 1'b1, 8'h00));
        drive_request(draw_request(COORD_MAX, COORD_MAX, 1, 1, 1'b1, 8'hFF));
        drive_request(draw_request(256, 256, 0, 2560, 1'b1, 8'hFF));
        drive_request(draw_request(256, 256, 2560, COORD_MIN, 1'b0, 8'hFF));
        drive_request(draw_request(384, 64, 960, 640, 1'b1, CODE_LOWER_R));
        drive_request(draw_request(1536, 256, 1024, 1280, 1'b0, CODE_UPPER_R));
        drive_request(draw_request(768, -256, 1, 5120, 1'b0, 8'hFF));
        drive_request(plain_request(REQ_UNKNOWN));
        drive_request(read_request(1, 2));
        drive_request(read_request(3, 8));
        drive_request(read_request(200, 250));
        drain_replies();

        // Width beyond the store saturates.
        program_canvas(300, 1, 8'hFF);
        drive_request(plain_request(REQ_CLEAR));
        drive_request(draw_request(-256, 0, 76800, 256, 1'b1, 8'h00));
        drive_request(read_request(0, 255));
        drain_replies();

        program_canvas(1, MAX_SIDE, 8'h00);
        drive_request(plain_request(REQ_CLEAR));
        drive_request(draw_request(0, 2560, 256, 65280, 1'b0, 8'h5A));
        drain_replies();

        // Zero rows: nothing is visited.
        program_canvas(MAX_SIDE, 0, 8'h41);
        drive_request(plain_request(REQ_CLEAR));
        drive_request(draw_request(0, 0, 2560, 2560, 1'b1, 8'h11));
        drive_request(read_request(0, 0));
        drain_replies();

        for (lap = 0; lap < RANDOM_ROUNDS; lap++) begin
            if (lap == 3) begin
                send_gap_pct  = 78;
                recv_gap_pct <= 8;
            end
            if (lap == 6) begin
                send_gap_pct  = 0;
                recv_gap_pct <= 0;
            end
            pick = $urandom_range(7);
            if (lap == 6) begin
                cols = 3;
                rows = 3;
            end else if (pick == 0) begin
                cols = 1;
                rows = $urandom_range(24, 1);
            end else if (pick == 1) begin
                cols = MAX_SIDE;
                rows = $urandom_range(3, 1);
            end else if (pick == 2) begin
                cols = $urandom_range(511, 257);
                rows = $urandom_range(2, 1);
            end else if (pick == 3) begin
                cols = $urandom_range(3, 1);
                rows = MAX_SIDE;
            end else begin
                cols = $urandom_range(24, 2);
                rows = $urandom_range(24, 2);
            end
            program_canvas(cols, rows, $urandom_range(255));
            // Hold replies back so the unit fills and stalls its input.
            if (lap == 6) hold_asked <= hold_asked + 1;
            for (n = 0; n < ROUND_ITEMS; n++)
                drive_request(random_request());
            drain_replies();
        end

        repeat (8) @(posedge i_clk);
        if (fail_count == 0)
            $display("rectangle_raster_fill_unit verification clean");
        else
            $display("rectangle_raster_fill_unit verification failed");
        $finish;
    end

endmodule

/* filelist.f */
+incdir+rtl/core
rtl/core/rrf_pkg.sv
rtl/core/rrf_ifs.sv
rtl/core/rrf_ram.sv
rtl/core/rrf_axis_unit.sv
rtl/core/rrf_seq.sv
rtl/core/rectangle_raster_fill_unit.sv
rtl/core/rrf_checker.sv
tb/rrf_canvas_monitor.sv
tb/testbench.sv
